// ===== rtl/core/gbsp_pkg.sv =====
// Shared constants, widths, command and status codes and the controller state type
// for the breadth-first shortest path block. Depends on nothing.
package gbsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_DEGREE   = 8;

    localparam int VX_W     = $clog2(MAX_VERTICES);
    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int ADJ_AW   = $clog2(ADJ_DEPTH);

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GROW   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_PATH = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SIZE    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_SAME    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RESP,
        S_GROW,
        S_SET,
        S_INS_A,
        S_INS_B,
        S_INS_C,
        S_INS_D,
        S_INIT,
        S_POP,
        S_VERT,
        S_CHK,
        S_NB,
        S_DONE,
        S_WALK,
        S_WALK2,
        S_EMIT_RD,
        S_EMIT_WR
    } state_t;

endpackage

// ===== rtl/core/graph_bfs_shortest_path.sv =====
// Top level of the breadth-first shortest path block: command controller, graph
// stores and result register. Depends on gbsp_pkg and gbsp_ram.
//
// Usage: commands enter on the s_ channel (command in s_tuser), results leave on
// the m_ channel (status in m_tuser, path vertex in m_tdata, m_tlast on the final
// result item of a command). One command is handled at a time; s_tready is high
// while the controller waits for a command, also when a result still sits unread
// in the output register.
// Grow initialises one new vertex per cycle; insert reads both degrees, then writes
// the two new slots unless a list is full. A search marks the origin, dequeues each
// vertex and reads its adjacency words, decides whether the target was reached,
// walks the parents back from the target and emits the path from the origin. The
// adjacency memory read port delivers one word a cycle while neighbours are scanned.
// Reset clears the vertex count, the controller and the output register; the
// stores need no clearing because a vertex is always initialised by grow before
// it can be read. If the receiver stalls, the output register holds its item
// and the controller waits before pushing the next one.
module graph_bfs_shortest_path
    import gbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] first_vertex, [11:6] second_vertex, [12] active_flag,
    // [19:13] new_count, [23:20] zero
    input  logic [23:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] path_vertex, [7:6] zero
    output logic [7:0]  m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]    vcount_reg, vcount_next;
    logic [VX_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic                flag_reg, flag_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DEG_W-1:0]    dega_reg, dega_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic [DEG_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    head_reg, head_next, tail_reg, tail_next;
    logic [VX_W-1:0]     v_reg, v_next;
    logic [VX_W-1:0]     len_reg, len_next;
    logic [MAX_VERTICES-1:0] disc_reg, disc_next;
    logic                mvalid_reg, mvalid_next;
    logic [STATUS_W-1:0] mstatus_reg, mstatus_next;
    logic [VX_W-1:0]     mvertex_reg, mvertex_next;
    logic                mlast_reg, mlast_next;

    // Memory ports
    logic              adj_we, adj_re;
    logic [ADJ_AW-1:0] adj_wa, adj_ra;
    logic [VX_W-1:0]   adj_wd, adj_rd;
    logic              deg_we, deg_re;
    logic [VX_W-1:0]   deg_wa, deg_ra;
    logic [DEG_W-1:0]  deg_wd, deg_rd;
    logic              act_we, act_re;
    logic [VX_W-1:0]   act_wa, act_ra;
    logic [0:0]        act_wd, act_rd;
    logic              par_we, par_re;
    logic [VX_W-1:0]   par_wa, par_ra, par_wd, par_rd;
    logic              que_we, que_re;
    logic [VX_W-1:0]   que_wa, que_ra, que_wd, que_rd;
    logic              pth_we, pth_re;
    logic [VX_W-1:0]   pth_wa, pth_ra, pth_wd, pth_rd;

    logic [CMD_W-1:0]  in_cmd;
    logic [VX_W-1:0]   in_a, in_b;
    logic [CNT_W-1:0]  in_cnt;
    logic              push_ok;
    logic              full;
    logic              fresh;

    function automatic logic [ADJ_AW-1:0] adj_addr(input logic [VX_W-1:0] v,
                                                   input logic [DEG_W-1:0] k);
        adj_addr = ADJ_AW'(v) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(k);
    endfunction

    assign in_cmd = s_tuser;
    assign in_a   = s_tdata[5:0];
    assign in_b   = s_tdata[11:6];
    assign in_cnt = s_tdata[19:13];

    assign s_tready = (state_reg == S_IDLE);
    assign push_ok  = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mstatus_reg;
    assign m_tdata  = {2'b00, mvertex_reg};
    assign m_tlast  = mlast_reg;

    // A self loop needs two free slots in one list.
    assign full = (a_reg == b_reg)
                ? ((DEG_W + 1)'(dega_reg) + (DEG_W + 1)'(2) > (DEG_W + 1)'(MAX_DEGREE))
                : ((dega_reg >= DEG_W'(MAX_DEGREE)) || (deg_rd >= DEG_W'(MAX_DEGREE)));

    assign fresh = (CNT_W'(adj_rd) < CNT_W'(MAX_VERTICES)) && !disc_reg[adj_rd];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            flag_reg    <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            status_reg  <= STAT_OK;
            dega_reg    <= '0;
            deg_reg     <= '0;
            k_reg       <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            v_reg       <= '0;
            len_reg     <= '0;
            disc_reg    <= '0;
            mvalid_reg  <= 1'b0;
            mstatus_reg <= STAT_OK;
            mvertex_reg <= '0;
            mlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            flag_reg    <= flag_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            status_reg  <= status_next;
            dega_reg    <= dega_next;
            deg_reg     <= deg_next;
            k_reg       <= k_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            v_reg       <= v_next;
            len_reg     <= len_next;
            disc_reg    <= disc_next;
            mvalid_reg  <= mvalid_next;
            mstatus_reg <= mstatus_next;
            mvertex_reg <= mvertex_next;
            mlast_reg   <= mlast_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        flag_next    = flag_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        dega_next    = dega_reg;
        deg_next     = deg_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        v_next       = v_reg;
        len_next     = len_reg;
        disc_next    = disc_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mstatus_next = mstatus_reg;
        mvertex_next = mvertex_reg;
        mlast_next   = mlast_reg;

        adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_re = 1'b0; adj_ra = '0;
        deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_re = 1'b0; deg_ra = '0;
        act_we = 1'b0; act_wa = '0; act_wd = '0; act_re = 1'b0; act_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_re = 1'b0; par_ra = '0;
        que_we = 1'b0; que_wa = '0; que_wd = '0; que_re = 1'b0; que_ra = '0;
        pth_we = 1'b0; pth_wa = '0; pth_wd = '0; pth_re = 1'b0; pth_ra = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next      = in_a;
                    b_next      = in_b;
                    flag_next   = s_tdata[12];
                    cnt_next    = in_cnt;
                    idx_next    = vcount_reg;
                    status_next = STAT_OK;
                    state_next  = S_RESP;
                    case (in_cmd)
                        CMD_CLEAR:
                        begin
                            vcount_next = '0;
                        end
                        CMD_GROW:
                        begin
                            if (in_cnt <= vcount_reg || in_cnt > CNT_W'(MAX_VERTICES))
                                status_next = STAT_SIZE;
                            else
                                state_next = S_GROW;
                        end
                        CMD_INSERT:
                        begin
                            if (CNT_W'(in_a) >= vcount_reg || CNT_W'(in_b) >= vcount_reg)
                                status_next = STAT_RANGE;
                            else
                                state_next = S_INS_A;
                        end
                        CMD_SET:
                        begin
                            if (CNT_W'(in_a) >= vcount_reg)
                                status_next = STAT_RANGE;
                            else
                                state_next = S_SET;
                        end
                        CMD_SEARCH:
                        begin
                            if (CNT_W'(in_a) >= vcount_reg || CNT_W'(in_b) >= vcount_reg)
                                status_next = STAT_RANGE;
                            else if (in_a == in_b)
                                status_next = STAT_SAME;
                            else
                                state_next = S_INIT;
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (push_ok)
                begin
                    mvalid_next  = 1'b1;
                    mstatus_next = status_reg;
                    mvertex_next = '0;
                    mlast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_GROW:
            begin
                deg_we = 1'b1;
                deg_wa = idx_reg[VX_W-1:0];
                deg_wd = '0;
                act_we = 1'b1;
                act_wa = idx_reg[VX_W-1:0];
                act_wd = 1'b1;
                if (idx_reg + CNT_W'(1) == cnt_reg)
                begin
                    vcount_next = cnt_reg;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_SET:
            begin
                act_we     = 1'b1;
                act_wa     = a_reg;
                act_wd     = flag_reg;
                state_next = S_RESP;
            end
            S_INS_A:
            begin
                deg_re     = 1'b1;
                deg_ra     = a_reg;
                state_next = S_INS_B;
            end
            S_INS_B:
            begin
                dega_next  = deg_rd;
                deg_re     = 1'b1;
                deg_ra     = b_reg;
                state_next = S_INS_C;
            end
            S_INS_C:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    adj_we = 1'b1;
                    adj_wa = adj_addr(a_reg, dega_reg);
                    adj_wd = b_reg;
                    deg_we = 1'b1;
                    deg_wa = a_reg;
                    deg_wd = dega_reg + DEG_W'(1);
                    // For a self loop the second slot follows the first.
                    deg_next   = (a_reg == b_reg) ? dega_reg + DEG_W'(1) : deg_rd;
                    state_next = S_INS_D;
                end
            end
            S_INS_D:
            begin
                adj_we     = 1'b1;
                adj_wa     = adj_addr(b_reg, deg_reg);
                adj_wd     = a_reg;
                deg_we     = 1'b1;
                deg_wa     = b_reg;
                deg_wd     = deg_reg + DEG_W'(1);
                state_next = S_RESP;
            end
            S_INIT:
            begin
                disc_next        = '0;
                disc_next[a_reg] = 1'b1;
                par_we     = 1'b1;
                par_wa     = a_reg;
                par_wd     = a_reg;
                que_we     = 1'b1;
                que_wa     = '0;
                que_wd     = a_reg;
                head_next  = '0;
                tail_next  = CNT_W'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    que_re     = 1'b1;
                    que_ra     = head_reg[VX_W-1:0];
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_VERT;
                end
            end
            S_VERT:
            begin
                v_next     = que_rd;
                act_re     = 1'b1;
                act_ra     = que_rd;
                deg_re     = 1'b1;
                deg_ra     = que_rd;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!act_rd[0] || deg_rd == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    deg_next   = deg_rd;
                    k_next     = '0;
                    adj_re     = 1'b1;
                    adj_ra     = adj_addr(v_reg, '0);
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                // One adjacency word arrives each cycle while the next is requested.
                if (fresh)
                begin
                    disc_next[adj_rd] = 1'b1;
                    par_we = 1'b1;
                    par_wa = adj_rd;
                    par_wd = v_reg;
                    if (adj_rd != b_reg && tail_reg < CNT_W'(MAX_VERTICES))
                    begin
                        que_we    = 1'b1;
                        que_wa    = tail_reg[VX_W-1:0];
                        que_wd    = adj_rd;
                        tail_next = tail_reg + CNT_W'(1);
                    end
                end
                if (fresh && adj_rd == b_reg)
                begin
                    state_next = S_DONE;
                end
                else if (k_reg + DEG_W'(1) < deg_reg)
                begin
                    k_next = k_reg + DEG_W'(1);
                    adj_re = 1'b1;
                    adj_ra = adj_addr(v_reg, k_reg + DEG_W'(1));
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_DONE:
            begin
                if (!disc_reg[b_reg])
                begin
                    status_next = STAT_NO_PATH;
                    state_next  = S_RESP;
                end
                else
                begin
                    v_next     = b_reg;
                    len_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                pth_we = 1'b1;
                pth_wa = len_reg;
                if (v_reg == a_reg || len_reg == VX_W'(MAX_VERTICES - 1))
                begin
                    pth_wd     = a_reg;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    pth_wd     = v_reg;
                    par_re     = 1'b1;
                    par_ra     = v_reg;
                    len_next   = len_reg + VX_W'(1);
                    state_next = S_WALK2;
                end
            end
            S_WALK2:
            begin
                v_next     = par_rd;
                state_next = S_WALK;
            end
            S_EMIT_RD:
            begin
                pth_re     = 1'b1;
                pth_ra     = len_reg;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                // The buffer was filled from the target end, so it is read backwards.
                if (push_ok)
                begin
                    mvalid_next  = 1'b1;
                    mstatus_next = STAT_OK;
                    mvertex_next = pth_rd;
                    mlast_next   = (len_reg == '0);
                    if (len_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        len_next   = len_reg - VX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    gbsp_ram #(.WIDTH(VX_W), .DEPTH(ADJ_DEPTH)) u_adj (
        .clk(clk), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
        .rd_en(adj_re), .rd_addr(adj_ra), .rd_data(adj_rd)
    );

    gbsp_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg (
        .clk(clk), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
        .rd_en(deg_re), .rd_addr(deg_ra), .rd_data(deg_rd)
    );

    gbsp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_act (
        .clk(clk), .wr_en(act_we), .wr_addr(act_wa), .wr_data(act_wd),
        .rd_en(act_re), .rd_addr(act_ra), .rd_data(act_rd)
    );

    gbsp_ram #(.WIDTH(VX_W), .DEPTH(MAX_VERTICES)) u_par (
        .clk(clk), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
        .rd_en(par_re), .rd_addr(par_ra), .rd_data(par_rd)
    );

    gbsp_ram #(.WIDTH(VX_W), .DEPTH(MAX_VERTICES)) u_que (
        .clk(clk), .wr_en(que_we), .wr_addr(que_wa), .wr_data(que_wd),
        .rd_en(que_re), .rd_addr(que_ra), .rd_data(que_rd)
    );

    gbsp_ram #(.WIDTH(VX_W), .DEPTH(MAX_VERTICES)) u_pth (
        .clk(clk), .wr_en(pth_we), .wr_addr(pth_wa), .wr_data(pth_wd),
        .rd_en(pth_re), .rd_addr(pth_ra), .rd_data(pth_rd)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= CNT_W'(MAX_VERTICES)))
        else $error("search queue pointers out of order");

    a_origin_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> disc_reg[a_reg])
        else $error("origin not marked during search");

    a_expand_discovered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB) |-> disc_reg[v_reg])
        else $error("expanding an undiscovered vertex");

    a_no_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && !m_tready) |=> (mstatus_reg == $past(mstatus_reg)
                                       && mvertex_reg == $past(mvertex_reg)))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/gbsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for every store of the shortest path block. Depends on nothing.
module gbsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
